// ===== rtl/core/ppc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the PowerPC relocation patch pipeline.
// ----------------------------------------------------------------------------
package ppc_pkg;

  typedef enum logic [4:0] {
    MODE_NONE         = 5'd0,
    MODE_ADDR32       = 5'd1,
    MODE_ADDR14       = 5'd2,
    MODE_ADDR16_LO    = 5'd3,
    MODE_ADDR16_HI    = 5'd4,
    MODE_ADDR16_HA    = 5'd5,
    MODE_ADDR24       = 5'd6,
    MODE_ADDR30       = 5'd7,
    MODE_PLT16_LO     = 5'd8,
    MODE_PLT16_HI     = 5'd9,
    MODE_PLT16_HA     = 5'd10,
    MODE_PLT32        = 5'd11,
    MODE_REL14        = 5'd12,
    MODE_REL16_LO     = 5'd13,
    MODE_REL16_HI     = 5'd14,
    MODE_REL16_HA     = 5'd15,
    MODE_REL24        = 5'd16,
    MODE_PLTREL24     = 5'd17,
    MODE_REL32        = 5'd18,
    MODE_LOCAL24PC    = 5'd19,
    MODE_GOT16_LO     = 5'd20,
    MODE_GOT16_HI     = 5'd21,
    MODE_GOT16_HA     = 5'd22,
    MODE_TPREL16_LO   = 5'd23,
    MODE_TPREL16_HI   = 5'd24,
    MODE_TPREL16_HA   = 5'd25,
    MODE_DTPREL16_LO  = 5'd26,
    MODE_DTPREL16_HI  = 5'd27,
    MODE_DTPREL16_HA  = 5'd28,
    MODE_GOT_TLSGD16  = 5'd29,
    MODE_GOT_TLSLD16  = 5'd30,
    MODE_GOT_TPREL16  = 5'd31
  } mode_e;

  typedef enum logic [2:0] {
    FORM_NONE = 3'd0,
    FORM_WORD = 3'd1,
    FORM_LO   = 3'd2,
    FORM_HI   = 3'd3,
    FORM_HA   = 3'd4,
    FORM_B14  = 3'd5,
    FORM_B24  = 3'd6,
    FORM_B30  = 3'd7
  } form_e;

  typedef enum logic [3:0] {
    SRC_SA    = 4'd0,
    SRC_PC    = 4'd1,
    SRC_PLT   = 4'd2,
    SRC_GA    = 4'd3,
    SRC_TP    = 4'd4,
    SRC_DTP   = 4'd5,
    SRC_SLOT  = 4'd6,
    SRC_TLSLD = 4'd7,
    SRC_R24   = 4'd8,
    SRC_PLT24 = 4'd9
  } src_e;

  localparam logic [1:0]  WS_NONE = 2'd0;
  localparam logic [1:0]  WS_HALF = 2'd1;
  localparam logic [1:0]  WS_WORD = 2'd2;

  localparam logic [31:0] MASK_B14 = 32'hFFFF_0003;
  localparam logic [31:0] MASK_B24 = 32'hFC00_0003;
  localparam logic [31:0] MASK_B30 = 32'h0000_0003;
  localparam logic [31:0] HA_ROUND = 32'h0000_8000;

  typedef struct packed {
    form_e       form;
    src_e        src;
    logic [31:0] sa;
    logic [31:0] sp;
    logic [31:0] tk;
    logic [31:0] gg;
    logic [31:0] gpa;
    logic [31:0] ga;
    logic [31:0] slg;
    logic [31:0] tlg;
    logic [31:0] p;
    logic [31:0] old;
    logic        plt;
  } s1_t;

  typedef struct packed {
    form_e       form;
    src_e        src;
    logic [31:0] old;
    logic [31:0] sa;
    logic [31:0] pc;
    logic [31:0] pltv;
    logic [31:0] ga;
    logic [31:0] tp;
    logic [31:0] dtp;
    logic [31:0] slg;
    logic [31:0] tlg;
    logic [31:0] sp;
    logic [31:0] tk;
    logic        plt;
  } s2_t;

  typedef struct packed {
    form_e       form;
    logic [31:0] old;
    logic [31:0] value;
  } s3_t;

  function automatic logic in_reach24(input logic [31:0] v);
    in_reach24 = (v[31:25] == 7'h00) || (v[31:25] == 7'h7F);
  endfunction

endpackage

// ===== rtl/core/ppc32_reloc_patch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc32_reloc_patch
// Applies one 32-bit PowerPC ELF relocation per transfer.
// ----------------------------------------------------------------------------
// A relocation is transferred in at a rising edge with start high and busy
// low. busy is always low, so a new relocation can be taken in every cycle.
// The pipeline has four register stages: decode and first sums, the
// relative differences, value selection with the branch thunk rule, and
// the output format. The result appears on new_value_o, write_size_o and
// bad_kind_o with done_o high for exactly one cycle, from the output
// register of the format stage. Throughput is one result per cycle.
// The receiver cannot hold results off and the block never needs to,
// since every stage moves forward in every cycle.
// The configuration registers (got_base, gp_base, tp_base, dtp_base,
// tlsld_slot) sit at byte addresses 0, 4, 8, 12 and 16 of the APB port.
// The user must write them only while no relocation is in flight; the
// block itself does not enforce it. Reset clears the registers and all
// stage valid bits, so no result is produced until a new relocation
// arrives. bad_kind_o is always low since every kind code is supported.
// ----------------------------------------------------------------------------
module ppc32_reloc_patch import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  mode_i,
  input  logic [31:0] sym_addr_i,
  input  logic signed [31:0] addend_i,
  input  logic [31:0] place_i,
  input  logic [29:0] got_index_i,
  input  logic [31:0] old_word_i,
  input  logic [31:0] thunk_addr_i,
  input  logic        has_plt_i,
  input  logic [31:0] slot_addr_i,
  output logic        done_o,
  output logic [31:0] new_value_o,
  output logic [1:0]  write_size_o,
  output logic        bad_kind_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_GOT_BASE   = 3'd0;
  localparam logic [2:0] REG_GP_BASE    = 3'd1;
  localparam logic [2:0] REG_TP_BASE    = 3'd2;
  localparam logic [2:0] REG_DTP_BASE   = 3'd3;
  localparam logic [2:0] REG_TLSLD_SLOT = 3'd4;

  logic [31:0] got_base_q, gp_base_q, tp_base_q, dtp_base_q, tlsld_slot_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        in_valid;
  logic        s1_valid, s2_valid, s3_valid;
  s1_t         s1_data;
  s2_t         s2_data;
  s3_t         s3_data;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      got_base_q   <= '0;
      gp_base_q    <= '0;
      tp_base_q    <= '0;
      dtp_base_q   <= '0;
      tlsld_slot_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GOT_BASE:   got_base_q   <= pwdata;
        REG_GP_BASE:    gp_base_q    <= pwdata;
        REG_TP_BASE:    tp_base_q    <= pwdata;
        REG_DTP_BASE:   dtp_base_q   <= pwdata;
        REG_TLSLD_SLOT: tlsld_slot_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GOT_BASE:   prdata = got_base_q;
      REG_GP_BASE:    prdata = gp_base_q;
      REG_TP_BASE:    prdata = tp_base_q;
      REG_DTP_BASE:   prdata = dtp_base_q;
      REG_TLSLD_SLOT: prdata = tlsld_slot_q;
      default:        prdata = '0;
    endcase
  end

  ppc_add_stage u_add (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid),
    .mode_i       (mode_i),
    .sym_addr_i   (sym_addr_i),
    .addend_i     (addend_i),
    .place_i      (place_i),
    .got_index_i  (got_index_i),
    .old_word_i   (old_word_i),
    .thunk_addr_i (thunk_addr_i),
    .has_plt_i    (has_plt_i),
    .slot_addr_i  (slot_addr_i),
    .got_base_i   (got_base_q),
    .gp_base_i    (gp_base_q),
    .tlsld_slot_i (tlsld_slot_q),
    .valid_o      (s1_valid),
    .data_o       (s1_data)
  );

  ppc_diff_stage u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .data_i     (s1_data),
    .tp_base_i  (tp_base_q),
    .dtp_base_i (dtp_base_q),
    .valid_o    (s2_valid),
    .data_o     (s2_data)
  );

  ppc_sel_stage u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .data_o  (s3_data)
  );

  ppc_fmt_stage u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .data_i  (s3_data),
    .valid_o (done_o),
    .value_o (new_value_o),
    .size_o  (write_size_o)
  );

  assign bad_kind_o = 1'b0;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4))
    |-> (done_o == $past(start, 4)))
    else $error("Result strobe does not follow the input transfer by four cycles.");

  a_size_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (write_size_o == WS_NONE || write_size_o == WS_HALF ||
                write_size_o == WS_WORD))
    else $error("Result carries an illegal write size.");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_size_o == WS_NONE) |-> (new_value_o == 32'h0))
    else $error("A result without a write carries a nonzero value.");

  a_half_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_size_o == WS_HALF) |-> (new_value_o[31:16] == 16'h0))
    else $error("A halfword result has nonzero upper bits.");

  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid || s2_valid || s3_valid) |->
    ($stable(got_base_q) && $stable(gp_base_q) && $stable(tp_base_q) &&
     $stable(dtp_base_q) && $stable(tlsld_slot_q)))
    else $error("Configuration changed while a relocation was in flight.");
`endif

endmodule

// ===== rtl/core/ppc_add_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_add_stage
// First stage: decodes the kind and forms the first sums of every operand.
// ----------------------------------------------------------------------------
module ppc_add_stage import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [4:0]  mode_i,
  input  logic [31:0] sym_addr_i,
  input  logic [31:0] addend_i,
  input  logic [31:0] place_i,
  input  logic [29:0] got_index_i,
  input  logic [31:0] old_word_i,
  input  logic [31:0] thunk_addr_i,
  input  logic        has_plt_i,
  input  logic [31:0] slot_addr_i,
  input  logic [31:0] got_base_i,
  input  logic [31:0] gp_base_i,
  input  logic [31:0] tlsld_slot_i,
  output logic        valid_o,
  output s1_t         data_o
);

  logic        valid_q;
  s1_t         data_d, data_q;
  logic [31:0] g;

  assign g = {got_index_i, 2'b00};

  always_comb begin
    data_d      = '0;
    data_d.sa   = sym_addr_i + addend_i;
    data_d.sp   = sym_addr_i - place_i;
    data_d.tk   = thunk_addr_i - place_i;
    data_d.gg   = g + got_base_i;
    data_d.gpa  = gp_base_i + addend_i;
    data_d.ga   = g + addend_i;
    data_d.slg  = slot_addr_i - got_base_i;
    data_d.tlg  = tlsld_slot_i - got_base_i;
    data_d.p    = place_i;
    data_d.old  = old_word_i;
    data_d.plt  = has_plt_i;
    data_d.form = FORM_NONE;
    data_d.src  = SRC_SA;
    case (mode_e'(mode_i))
      MODE_NONE:        data_d.form = FORM_NONE;
      MODE_ADDR32:      data_d.form = FORM_WORD;
      MODE_ADDR14:      data_d.form = FORM_B14;
      MODE_ADDR16_LO:   data_d.form = FORM_LO;
      MODE_ADDR16_HI:   data_d.form = FORM_HI;
      MODE_ADDR16_HA:   data_d.form = FORM_HA;
      MODE_ADDR24:      data_d.form = FORM_B24;
      MODE_ADDR30:      data_d.form = FORM_B30;
      MODE_PLT16_LO:    begin data_d.form = FORM_LO;   data_d.src = SRC_PLT;   end
      MODE_PLT16_HI:    begin data_d.form = FORM_HI;   data_d.src = SRC_PLT;   end
      MODE_PLT16_HA:    begin data_d.form = FORM_HA;   data_d.src = SRC_PLT;   end
      MODE_PLT32:       begin data_d.form = FORM_WORD; data_d.src = SRC_PLT;   end
      MODE_REL14:       begin data_d.form = FORM_B14;  data_d.src = SRC_PC;    end
      MODE_REL16_LO:    begin data_d.form = FORM_LO;   data_d.src = SRC_PC;    end
      MODE_REL16_HI:    begin data_d.form = FORM_HI;   data_d.src = SRC_PC;    end
      MODE_REL16_HA:    begin data_d.form = FORM_HA;   data_d.src = SRC_PC;    end
      MODE_REL24:       begin data_d.form = FORM_B24;  data_d.src = SRC_R24;   end
      MODE_PLTREL24:    begin data_d.form = FORM_B24;  data_d.src = SRC_PLT24; end
      MODE_REL32:       begin data_d.form = FORM_WORD; data_d.src = SRC_PC;    end
      MODE_LOCAL24PC:   begin data_d.form = FORM_B24;  data_d.src = SRC_PC;    end
      MODE_GOT16_LO:    begin data_d.form = FORM_LO;   data_d.src = SRC_GA;    end
      MODE_GOT16_HI:    begin data_d.form = FORM_HI;   data_d.src = SRC_GA;    end
      MODE_GOT16_HA:    begin data_d.form = FORM_HA;   data_d.src = SRC_GA;    end
      MODE_TPREL16_LO:  begin data_d.form = FORM_LO;   data_d.src = SRC_TP;    end
      MODE_TPREL16_HI:  begin data_d.form = FORM_HI;   data_d.src = SRC_TP;    end
      MODE_TPREL16_HA:  begin data_d.form = FORM_HA;   data_d.src = SRC_TP;    end
      MODE_DTPREL16_LO: begin data_d.form = FORM_LO;   data_d.src = SRC_DTP;   end
      MODE_DTPREL16_HI: begin data_d.form = FORM_HI;   data_d.src = SRC_DTP;   end
      MODE_DTPREL16_HA: begin data_d.form = FORM_HA;   data_d.src = SRC_DTP;   end
      MODE_GOT_TLSGD16: begin data_d.form = FORM_LO;   data_d.src = SRC_SLOT;  end
      MODE_GOT_TLSLD16: begin data_d.form = FORM_LO;   data_d.src = SRC_TLSLD; end
      MODE_GOT_TPREL16: begin data_d.form = FORM_LO;   data_d.src = SRC_SLOT;  end
      default:          data_d.form = FORM_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/ppc_diff_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_diff_stage
// Second stage: PC-relative, PLT, TP- and DTP-relative differences.
// ----------------------------------------------------------------------------
module ppc_diff_stage import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  s1_t         data_i,
  input  logic [31:0] tp_base_i,
  input  logic [31:0] dtp_base_i,
  output logic        valid_o,
  output s2_t         data_o
);

  logic valid_q;
  s2_t  data_d, data_q;

  always_comb begin
    data_d      = '0;
    data_d.form = data_i.form;
    data_d.src  = data_i.src;
    data_d.old  = data_i.old;
    data_d.sa   = data_i.sa;
    data_d.pc   = data_i.sa - data_i.p;
    data_d.pltv = data_i.gg - data_i.gpa;
    data_d.ga   = data_i.ga;
    data_d.tp   = data_i.sa - tp_base_i;
    data_d.dtp  = data_i.sa - dtp_base_i;
    data_d.slg  = data_i.slg;
    data_d.tlg  = data_i.tlg;
    data_d.sp   = data_i.sp;
    data_d.tk   = data_i.tk;
    data_d.plt  = data_i.plt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/ppc_sel_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_sel_stage
// Third stage: picks the relocation value and applies the branch thunk rule.
// ----------------------------------------------------------------------------
module ppc_sel_stage import ppc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s2_t  data_i,
  output logic valid_o,
  output s3_t  data_o
);

  logic valid_q;
  s3_t  data_d, data_q;

  always_comb begin
    data_d      = '0;
    data_d.form = data_i.form;
    data_d.old  = data_i.old;
    case (data_i.src)
      SRC_SA:    data_d.value = data_i.sa;
      SRC_PC:    data_d.value = data_i.pc;
      SRC_PLT:   data_d.value = data_i.pltv;
      SRC_GA:    data_d.value = data_i.ga;
      SRC_TP:    data_d.value = data_i.tp;
      SRC_DTP:   data_d.value = data_i.dtp;
      SRC_SLOT:  data_d.value = data_i.slg;
      SRC_TLSLD: data_d.value = data_i.tlg;
      SRC_R24:   data_d.value = in_reach24(data_i.pc) ? data_i.pc : data_i.tk;
      SRC_PLT24: begin
        data_d.value = (data_i.plt || !in_reach24(data_i.sp)) ? data_i.tk : data_i.sp;
      end
      default:   data_d.value = data_i.sa;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/ppc_fmt_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_fmt_stage
// Last stage: halfword extraction, rounding and branch field merge.
// ----------------------------------------------------------------------------
module ppc_fmt_stage import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  s3_t         data_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic [1:0]  size_o
);

  logic        valid_q;
  logic [31:0] value_d, value_q;
  logic [1:0]  size_d, size_q;
  logic [31:0] ha;

  assign ha = data_i.value + HA_ROUND;

  always_comb begin
    value_d = '0;
    size_d  = WS_NONE;
    case (data_i.form)
      FORM_NONE: begin
        value_d = '0;
        size_d  = WS_NONE;
      end
      FORM_WORD: begin
        value_d = data_i.value;
        size_d  = WS_WORD;
      end
      FORM_LO: begin
        value_d = {16'h0000, data_i.value[15:0]};
        size_d  = WS_HALF;
      end
      FORM_HI: begin
        value_d = {16'h0000, data_i.value[31:16]};
        size_d  = WS_HALF;
      end
      FORM_HA: begin
        value_d = {16'h0000, ha[31:16]};
        size_d  = WS_HALF;
      end
      FORM_B14: begin
        value_d = (data_i.old & MASK_B14) | (data_i.value & ~MASK_B14);
        size_d  = WS_WORD;
      end
      FORM_B24: begin
        value_d = (data_i.old & MASK_B24) | (data_i.value & ~MASK_B24);
        size_d  = WS_WORD;
      end
      FORM_B30: begin
        value_d = (data_i.old & MASK_B30) | (data_i.value & ~MASK_B30);
        size_d  = WS_WORD;
      end
      default: begin
        value_d = '0;
        size_d  = WS_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      value_q <= value_d;
      size_q  <= size_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign size_o  = size_q;

endmodule
